// ===== hdl/hppc_pkg.sv =====
// ----------------------------------------------------------------------------
// hppc_pkg
// Shared types, register indexes and defaults for the horn controller.
// ----------------------------------------------------------------------------
package hppc_pkg;

  // field widths
  localparam int MODE_W    = 3;
  localparam int MS_W      = 16;
  localparam int STEP_IDX_W = 3;
  localparam int STEP_REGS = 5;
  localparam int CFG_IDX_W = 3;

  // default pattern length in steps
  localparam int PATTERN_STEPS_DEF = 5;

  // request kinds
  localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PULSE      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HOLD_START = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HOLD_STOP  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PATTERN    = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MS_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MS_4    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ON_MASK = 3'd5;

  // register reset values
  localparam logic [MS_W-1:0]      STEP_MS_DEF      = 16'd1000;
  localparam logic [MS_W-1:0]      STEP_MS_LAST_DEF = 16'd2000;
  localparam logic [STEP_REGS-1:0] STEP_ON_MASK_DEF = 5'd21;

  // counter saturation value
  localparam logic [MS_W-1:0] MS_MAX = '1;

  // configuration seen by the core
  typedef struct packed {
    logic [STEP_REGS-1:0][MS_W-1:0] step_ms;
    logic [STEP_REGS-1:0]           step_on_mask;
  } cfg_t;

  // status after one request
  typedef struct packed {
    logic                  horn_on;
    logic                  pulse_busy;
    logic                  hold_busy;
    logic                  pattern_busy;
    logic [STEP_IDX_W-1:0] pattern_index;
  } status_t;

  // saturating increment of a millisecond counter
  function automatic logic [MS_W-1:0] sat_inc(input logic [MS_W-1:0] v);
    return (v == MS_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== hdl/hppc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hppc_cfg_regs
// Pattern step lengths and on/off mask, written through a plain write port.
// ----------------------------------------------------------------------------
module hppc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hppc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hppc_pkg::MS_W-1:0]      cfg_wdata,
  output hppc_pkg::cfg_t                 cfg
);

  hppc_pkg::cfg_t cfg_r;

  // register writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < hppc_pkg::STEP_REGS - 1; i++) begin
        cfg_r.step_ms[i] <= hppc_pkg::STEP_MS_DEF;
      end
      cfg_r.step_ms[hppc_pkg::STEP_REGS-1] <= hppc_pkg::STEP_MS_LAST_DEF;
      cfg_r.step_on_mask <= hppc_pkg::STEP_ON_MASK_DEF;
    end else if (cfg_we) begin
      if (cfg_index <= hppc_pkg::REG_STEP_MS_4) begin
        cfg_r.step_ms[cfg_index] <= cfg_wdata;
      end else if (cfg_index == hppc_pkg::REG_STEP_ON_MASK) begin
        cfg_r.step_on_mask <= cfg_wdata[hppc_pkg::STEP_REGS-1:0];
      end
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/hppc_core.sv =====
// ----------------------------------------------------------------------------
// hppc_core
// Controller state and its one-request update: pulse, hold and end pattern.
// ----------------------------------------------------------------------------
module hppc_core #(
  parameter int PATTERN_STEPS = hppc_pkg::PATTERN_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_go,
  input  logic [hppc_pkg::MODE_W-1:0] req_mode,
  input  logic [hppc_pkg::MS_W-1:0]   req_pulse_ms,
  input  hppc_pkg::cfg_t              cfg,
  output hppc_pkg::status_t           status_nxt
);

  localparam int IW = hppc_pkg::STEP_IDX_W;
  localparam int MW = hppc_pkg::MS_W;
  localparam logic [IW-1:0] LAST_STEP_END = IW'(PATTERN_STEPS);

  logic          horn_r, horn_nxt;
  logic          pulse_r, pulse_nxt;
  logic          hold_r, hold_nxt;
  logic          pattern_r, pattern_nxt;
  logic [IW-1:0] step_idx_r, step_idx_nxt;
  logic [MW-1:0] step_el_r, step_el_nxt;
  logic [MW-1:0] pulse_el_r, pulse_el_nxt;
  logic [MW-1:0] pulse_len_r, pulse_len_nxt;

  logic [MW-1:0] step_el_inc;
  logic [MW-1:0] pulse_el_tick;
  logic [MW-1:0] cur_len;
  logic [IW-1:0] next_idx;
  logic          next_on;

  // current step length and on bit of the following step
  always_comb begin
    cur_len = '0;
    if (step_idx_r < IW'(hppc_pkg::STEP_REGS)) begin
      cur_len = cfg.step_ms[step_idx_r];
    end
    next_idx = step_idx_r + 1'b1;
    next_on  = 1'b0;
    if (next_idx < IW'(hppc_pkg::STEP_REGS)) begin
      next_on = cfg.step_on_mask[next_idx];
    end
  end

  assign step_el_inc   = hppc_pkg::sat_inc(step_el_r);
  assign pulse_el_tick = pulse_r ? hppc_pkg::sat_inc(pulse_el_r) : pulse_el_r;

  // next state for the request at hand
  always_comb begin
    horn_nxt      = horn_r;
    pulse_nxt     = pulse_r;
    hold_nxt      = hold_r;
    pattern_nxt   = pattern_r;
    step_idx_nxt  = step_idx_r;
    step_el_nxt   = step_el_r;
    pulse_el_nxt  = pulse_el_r;
    pulse_len_nxt = pulse_len_r;
    unique case (req_mode)
      hppc_pkg::MODE_TICK: begin
        pulse_el_nxt = pulse_el_tick;
        if (pattern_r) begin
          step_el_nxt = step_el_inc;
          if (step_el_inc >= cur_len) begin
            step_el_nxt = '0;
            if (next_idx >= LAST_STEP_END || next_idx == '0) begin
              pattern_nxt  = 1'b0;
              step_idx_nxt = '0;
              horn_nxt     = 1'b0;
            end else begin
              step_idx_nxt = next_idx;
              horn_nxt     = next_on;
            end
          end
        end else if (!hold_r && pulse_r && pulse_el_tick >= pulse_len_r) begin
          horn_nxt  = 1'b0;
          pulse_nxt = 1'b0;
        end
      end
      hppc_pkg::MODE_PULSE: begin
        if (!pulse_r && !hold_r) begin
          horn_nxt      = 1'b1;
          pulse_nxt     = 1'b1;
          pulse_len_nxt = req_pulse_ms;
          pulse_el_nxt  = '0;
        end
      end
      hppc_pkg::MODE_HOLD_START: begin
        if (!hold_r && !pattern_r) begin
          hold_nxt  = 1'b1;
          pulse_nxt = 1'b0;
          horn_nxt  = 1'b1;
        end
      end
      hppc_pkg::MODE_HOLD_STOP: begin
        if (hold_r) begin
          hold_nxt = 1'b0;
          horn_nxt = 1'b0;
        end
      end
      hppc_pkg::MODE_PATTERN: begin
        if (!pattern_r && !pulse_r) begin
          pattern_nxt  = 1'b1;
          step_idx_nxt = '0;
          step_el_nxt  = '0;
          horn_nxt     = cfg.step_on_mask[0];
        end
      end
      default: begin
      end
    endcase
  end

  // state registers, updated once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horn_r      <= 1'b0;
      pulse_r     <= 1'b0;
      hold_r      <= 1'b0;
      pattern_r   <= 1'b0;
      step_idx_r  <= '0;
      step_el_r   <= '0;
      pulse_el_r  <= '0;
      pulse_len_r <= '0;
    end else if (req_go) begin
      horn_r      <= horn_nxt;
      pulse_r     <= pulse_nxt;
      hold_r      <= hold_nxt;
      pattern_r   <= pattern_nxt;
      step_idx_r  <= step_idx_nxt;
      step_el_r   <= step_el_nxt;
      pulse_el_r  <= pulse_el_nxt;
      pulse_len_r <= pulse_len_nxt;
    end
  end

  // status as it stands after this request
  always_comb begin
    status_nxt.horn_on       = horn_nxt;
    status_nxt.pulse_busy    = pulse_nxt;
    status_nxt.hold_busy     = hold_nxt;
    status_nxt.pattern_busy  = pattern_nxt;
    status_nxt.pattern_index = pattern_nxt ? step_idx_nxt : '0;
  end

endmodule

// ===== hdl/horn_pulse_hold_pattern_controller_top.sv =====
// ----------------------------------------------------------------------------
// horn_pulse_hold_pattern_controller_top
// Horn driver for timed pulses, hold and a configurable end pattern.
// ----------------------------------------------------------------------------
//   channel   direction  payload
//   in_       slave      tdata: mode[2:0], pulse_ms[18:3]
//   out_      master     tdata: horn_on, pulse_busy, hold_busy, pattern_busy,
//                               pattern_index[6:4]
//   cfg_      write      cfg_index selects step_ms_0..4 or step_on_mask
//
// One request per cycle while the result side keeps up; a result is valid once
// its request has passed the input register, then the state update into the
// result register.
// Reset (rst_n low, synchronous) clears the state and loads the default steps.
// A stalled result holds in the result register; the input register keeps
// taking requests as long as it empties in the same cycle.
// ----------------------------------------------------------------------------
module horn_pulse_hold_pattern_controller_top #(
  parameter int PATTERN_STEPS = hppc_pkg::PATTERN_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // mode[2:0], pulse_ms[18:3]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // horn_on, pulse_busy,
                                                     // hold_busy, pattern_busy,
                                                     // pattern_index[6:4]
  input  logic                           cfg_we,
  input  logic [hppc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hppc_pkg::MS_W-1:0]      cfg_wdata
);

  hppc_pkg::cfg_t    cfg;
  hppc_pkg::status_t status_nxt;
  hppc_pkg::status_t res_r;

  logic                        in_valid_r;
  logic [hppc_pkg::MODE_W-1:0] mode_r;
  logic [hppc_pkg::MS_W-1:0]   pulse_ms_r;
  logic                        out_valid_r;
  logic                        req_go;

  // request moves into the result register when that register frees up
  assign req_go    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || req_go;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mode_r     <= in_tdata[2:0];
      pulse_ms_r <= in_tdata[18:3];
    end
  end

  // configuration registers
  hppc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // controller state and update
  hppc_core #(
    .PATTERN_STEPS (PATTERN_STEPS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_go       (req_go),
    .req_mode     (mode_r),
    .req_pulse_ms (pulse_ms_r),
    .cfg          (cfg),
    .status_nxt   (status_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_go) begin
      res_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.pattern_index, res_r.pattern_busy,
                       res_r.hold_busy, res_r.pulse_busy, res_r.horn_on};

  // pulse and hold never pending together
  a_pulse_hold_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.pulse_busy && res_r.hold_busy))
    else $error("pulse and hold both active");

  // step index reads zero while the pattern is idle
  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.pattern_busy) |-> (res_r.pattern_index == '0))
    else $error("pattern index set while pattern idle");

  // step index stays within the pattern
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.pattern_index < hppc_pkg::STEP_IDX_W'(PATTERN_STEPS)))
    else $error("pattern index past last step");

  // a taken request is held in the input register next cycle
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> in_valid_r)
    else $error("accepted request lost");

endmodule

// ===== sim/tb_horn_pulse_hold_pattern_controller_top.sv =====
// ----------------------------------------------------------------------------
// tb_horn_pulse_hold_pattern_controller_top
// Self-checking bench for the horn pulse, hold and end-pattern controller.
// A cycle-free model of the controller predicts the status after every
// accepted request. A checker compares each result, field by field, against
// the oldest prediction. Stimulus covers the reset step table, directed corner
// cases, the longest pulse, and a sweep of step settings with random request
// sequences. Back-pressure and idle gaps are applied on both sides.
// ----------------------------------------------------------------------------
module tb_horn_pulse_hold_pattern_controller_top;

  localparam int MODE_W     = hppc_pkg::MODE_W;
  localparam int MS_W       = hppc_pkg::MS_W;
  localparam int STEP_IDX_W = hppc_pkg::STEP_IDX_W;
  localparam int STEP_REGS  = hppc_pkg::STEP_REGS;
  localparam int CFG_IDX_W  = hppc_pkg::CFG_IDX_W;

  // spare request codes that the block must ignore
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  localparam int NUM_STEPS        = hppc_pkg::PATTERN_STEPS_DEF;
  localparam int DRAIN_SLACK      = 6;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int PRINT_LIMIT      = 40;
  localparam int LONG_PULSE_TICKS = 20;
  localparam int SWEEP_ITEMS      = 30;

  typedef struct packed {
    logic                  horn_on;
    logic                  pulse_busy;
    logic                  hold_busy;
    logic                  pattern_busy;
    logic [STEP_IDX_W-1:0] pattern_index;
  } horn_status_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [23:0]          in_tdata = '0;   // mode[2:0], pulse_ms[18:3]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;       // horn_on, pulse_busy, hold_busy,
                                         // pattern_busy, pattern_index[6:4]
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MS_W-1:0]      cfg_wdata = '0;

  // controller model state
  logic                  horn_now;
  logic                  pulse_pending;
  logic                  hold_active;
  logic                  pattern_running;
  logic [STEP_IDX_W-1:0] step_now;
  logic [MS_W-1:0]       step_elapsed_ms;
  logic [MS_W-1:0]       pulse_elapsed_ms;
  logic [MS_W-1:0]       pulse_len_ms;
  logic [MS_W-1:0]       step_len_ms [STEP_REGS];
  logic [STEP_REGS-1:0]  step_on_bits;

  horn_status_t pending_status[$];
  int           mismatch_count = 0;
  int           sent_count = 0;
  int           burst_left = 0;
  int           cycle_count = 0;
  int           holdoff_request = 0;
  bit           sender_idles = 1'b1;
  bit           receiver_stalls = 1'b1;

  horn_pulse_hold_pattern_controller_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("horn_pulse_hold_pattern_controller_top: mismatch");
      $finish;
    end
  end

  function automatic logic [MS_W-1:0] bump_ms(input logic [MS_W-1:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // status after one request, updating the model state
  function automatic horn_status_t predict_status(input logic [MODE_W-1:0] mode,
                                                  input logic [MS_W-1:0] ms);
    horn_status_t          s;
    logic [MS_W-1:0]       cur_len;
    logic [STEP_IDX_W-1:0] next_step;
    case (mode)
      hppc_pkg::MODE_TICK: begin
        if (pulse_pending) pulse_elapsed_ms = bump_ms(pulse_elapsed_ms);
        if (pattern_running) begin
          step_elapsed_ms = bump_ms(step_elapsed_ms);
          cur_len = (step_now < STEP_REGS) ? step_len_ms[step_now] : '0;
          if (step_elapsed_ms >= cur_len) begin
            next_step = step_now + 3'd1;
            // end of the pattern: horn off even if hold is still active
            if (next_step >= NUM_STEPS || next_step == 3'd0) begin
              pattern_running = 1'b0;
              step_now        = '0;
              step_elapsed_ms = '0;
              horn_now        = 1'b0;
            end else begin
              step_now        = next_step;
              step_elapsed_ms = '0;
              horn_now        = (next_step < STEP_REGS) ? step_on_bits[next_step] : 1'b0;
            end
          end
        end else if (!hold_active && pulse_pending && pulse_elapsed_ms >= pulse_len_ms) begin
          horn_now      = 1'b0;
          pulse_pending = 1'b0;
        end
      end
      hppc_pkg::MODE_PULSE: begin
        if (!pulse_pending && !hold_active) begin
          horn_now         = 1'b1;
          pulse_pending    = 1'b1;
          pulse_len_ms     = ms;
          pulse_elapsed_ms = '0;
        end
      end
      hppc_pkg::MODE_HOLD_START: begin
        if (!hold_active && !pattern_running) begin
          hold_active   = 1'b1;
          pulse_pending = 1'b0;
          horn_now      = 1'b1;
        end
      end
      hppc_pkg::MODE_HOLD_STOP: begin
        if (hold_active) begin
          hold_active = 1'b0;
          horn_now    = 1'b0;
        end
      end
      hppc_pkg::MODE_PATTERN: begin
        if (!pattern_running && !pulse_pending) begin
          pattern_running = 1'b1;
          step_now        = '0;
          step_elapsed_ms = '0;
          horn_now        = step_on_bits[0];
        end
      end
      default: ;
    endcase
    s.horn_on       = horn_now;
    s.pulse_busy    = pulse_pending;
    s.hold_busy     = hold_active;
    s.pattern_busy  = pattern_running;
    s.pattern_index = pattern_running ? step_now : '0;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    horn_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_status.size() == 0) begin
        report_mismatch("result with no request pending", out_tdata, 0);
      end else begin
        want = pending_status.pop_front();
        if (out_tdata[0] !== want.horn_on)
          report_mismatch("horn_on", out_tdata[0], want.horn_on);
        if (out_tdata[1] !== want.pulse_busy)
          report_mismatch("pulse_busy", out_tdata[1], want.pulse_busy);
        if (out_tdata[2] !== want.hold_busy)
          report_mismatch("hold_busy", out_tdata[2], want.hold_busy);
        if (out_tdata[3] !== want.pattern_busy)
          report_mismatch("pattern_busy", out_tdata[3], want.pattern_busy);
        if (out_tdata[6:4] !== want.pattern_index)
          report_mismatch("pattern_index", out_tdata[6:4], want.pattern_index);
      end
    end
  end

  // result side ready: free running, stall pattern or long hold-off
  initial begin : result_sink
    logic [15:0] stall_bits;
    int          hold_left;
    stall_bits = 16'hA5C3;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (holdoff_request != 0) begin
        hold_left       = holdoff_request;
        holdoff_request = 0;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (!receiver_stalls) begin
        out_tready = 1'b1;
      end else begin
        if ($urandom_range(0, 47) == 0) stall_bits = 16'($urandom) | 16'h0101;
        stall_bits = {stall_bits[14:0], stall_bits[15]};
        out_tready = stall_bits[0];
      end
    end
  end

  // one request, with burst and gap idling on the sender side
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [MS_W-1:0] ms);
    int gap;
    if (burst_left == 0) begin
      gap = sender_idles ? $urandom_range(1, 6) : 0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_tdata  = {5'b0, ms, mode};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_status.push_back(predict_status(mode, ms));
    sent_count++;
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_noise();
    send_request(MODE_W'($urandom_range(0, 7)), 16'($urandom));
  endtask

  function automatic logic [MS_W-1:0] pick_pulse_ms();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
  endfunction

  // wait until every predicted result has come back
  task automatic drain_results();
    while (pending_status.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] value);
    cfg_index = idx;
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx < STEP_REGS) step_len_ms[idx] = value;
    else if (idx == hppc_pkg::REG_STEP_ON_MASK) step_on_bits = value[STEP_REGS-1:0];
  endtask

  task automatic run_pattern_ticks(input int cap);
    int n;
    n = 0;
    while (pattern_running && n < cap) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_request(hppc_pkg::MODE_TICK, 16'($urandom));
      n++;
    end
  endtask

  // bring the controller to no pulse, no hold, no pattern
  task automatic settle_idle();
    while (pattern_running) send_request(hppc_pkg::MODE_TICK, 16'd0);
    send_request(hppc_pkg::MODE_HOLD_START, 16'd0);
    send_request(hppc_pkg::MODE_HOLD_STOP, 16'd0);
  endtask

  // random request sequences, mostly well formed
  task automatic run_random_mix(input int count);
    int first;
    int n;
    first = sent_count;
    while (sent_count - first < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          send_request(hppc_pkg::MODE_PATTERN, 16'($urandom));
          run_pattern_ticks(90);
        end
        3, 4: begin
          send_request(hppc_pkg::MODE_PULSE, pick_pulse_ms());
          n = 0;
          while (pulse_pending && n < 20) begin
            send_request(hppc_pkg::MODE_TICK, 16'($urandom));
            n++;
          end
        end
        5, 6: begin
          send_request(hppc_pkg::MODE_HOLD_START, 16'($urandom));
          repeat ($urandom_range(0, 4)) send_request(hppc_pkg::MODE_TICK, 16'($urandom));
          if ($urandom_range(0, 1) == 1) begin
            send_request(hppc_pkg::MODE_PATTERN, 16'($urandom));
            run_pattern_ticks(90);
          end else begin
            send_request(hppc_pkg::MODE_PULSE, pick_pulse_ms());
          end
          send_request(hppc_pkg::MODE_HOLD_STOP, 16'($urandom));
        end
        default: repeat ($urandom_range(1, 4)) send_noise();
      endcase
    end
  endtask

  // first step of the pattern with the step table as it comes out of reset,
  // run until it hands over to the second step
  task automatic test_default_steps();
    send_request(hppc_pkg::MODE_PATTERN, 16'd0);
    while (pattern_running && step_now == '0) begin
      if ($urandom_range(0, 49) == 0) send_noise();
      else send_request(hppc_pkg::MODE_TICK, 16'($urandom));
    end
    repeat (3) send_request(hppc_pkg::MODE_TICK, 16'($urandom));
  endtask

  // refusals, cancels, zero-length pulse and step, unused codes
  task automatic test_directed_cases();
    drain_results();
    write_register(hppc_pkg::REG_STEP_MS_0,        16'd2);
    write_register(hppc_pkg::REG_STEP_MS_0 + 3'd1, 16'd0);
    write_register(hppc_pkg::REG_STEP_MS_0 + 3'd2, 16'd1);
    write_register(hppc_pkg::REG_STEP_MS_0 + 3'd3, 16'd3);
    write_register(hppc_pkg::REG_STEP_MS_4,        16'd1);
    write_register(hppc_pkg::REG_STEP_ON_MASK,     16'h0016);
    settle_idle();
    send_request(MODE_SPARE_LO, 16'hFFFF);
    send_request(MODE_SPARE_HI, 16'h0000);
    // zero-length pulse expires on the first tick
    send_request(hppc_pkg::MODE_PULSE, 16'd0);
    send_request(hppc_pkg::MODE_TICK, 16'd0);
    // longest pulse, then requests that it must refuse
    send_request(hppc_pkg::MODE_PULSE, 16'hFFFF);
    send_request(hppc_pkg::MODE_PULSE, 16'd1);
    send_request(hppc_pkg::MODE_PATTERN, 16'd0);
    // hold cancels the pulse and refuses pulse and a second hold
    send_request(hppc_pkg::MODE_HOLD_START, 16'd0);
    send_request(hppc_pkg::MODE_PULSE, 16'd0);
    send_request(hppc_pkg::MODE_HOLD_START, 16'd0);
    // pattern accepted during hold, hold refused during pattern
    send_request(hppc_pkg::MODE_PATTERN, 16'd0);
    send_request(hppc_pkg::MODE_HOLD_START, 16'd0);
    send_request(hppc_pkg::MODE_TICK, 16'd0);
    // hold stop turns the horn off even while the pattern runs
    send_request(hppc_pkg::MODE_HOLD_STOP, 16'd0);
    send_request(hppc_pkg::MODE_HOLD_STOP, 16'd0);
    // pulse accepted during pattern, pattern restart refused
    send_request(hppc_pkg::MODE_PULSE, 16'd3);
    send_request(hppc_pkg::MODE_PATTERN, 16'd0);
    repeat (9) send_request(hppc_pkg::MODE_TICK, 16'd0);
  endtask

  // longest pulse started during the pattern keeps running after it ends,
  // at full rate on both sides, until hold cancels it
  task automatic test_long_pulse();
    settle_idle();
    drain_results();
    write_register(hppc_pkg::REG_STEP_MS_0,        16'd40);
    write_register(hppc_pkg::REG_STEP_MS_0 + 3'd1, 16'd0);
    write_register(hppc_pkg::REG_STEP_MS_0 + 3'd2, 16'd1);
    write_register(hppc_pkg::REG_STEP_MS_0 + 3'd3, 16'd0);
    write_register(hppc_pkg::REG_STEP_MS_4,        16'd2);
    write_register(hppc_pkg::REG_STEP_ON_MASK,     16'h0015);
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    send_request(hppc_pkg::MODE_PATTERN, 16'd0);
    send_request(hppc_pkg::MODE_PULSE, 16'hFFFF);
    while (pattern_running) send_request(hppc_pkg::MODE_TICK, 16'($urandom));
    repeat (LONG_PULSE_TICKS) send_request(hppc_pkg::MODE_TICK, 16'($urandom));
    send_request(hppc_pkg::MODE_HOLD_START, 16'd0);
    send_request(hppc_pkg::MODE_HOLD_STOP, 16'd0);
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // several step settings, extremes among them, each with random traffic
  task automatic test_setting_sweep();
    logic [MS_W-1:0]      len;
    logic [STEP_REGS-1:0] mask;
    for (int k = 0; k < 6; k++) begin
      drain_results();
      for (int i = 0; i < STEP_REGS; i++) begin
        case (k)
          0, 1:    len = 16'd0;
          2:       len = 16'($urandom_range(1, 6));
          3:       len = 16'($urandom_range(0, 3));
          4:       len = (i == STEP_REGS - 1) ? 16'd40 : 16'($urandom_range(0, 8));
          default: len = 16'($urandom_range(2, 10));
        endcase
        write_register(hppc_pkg::REG_STEP_MS_0 + CFG_IDX_W'(i), len);
      end
      mask = (k == 0) ? 5'h00 : (k == 1) ? 5'h1F : 5'($urandom);
      write_register(hppc_pkg::REG_STEP_ON_MASK, {11'b0, mask});
      run_random_mix(SWEEP_ITEMS);
    end
  endtask

  // long result stall fills the block, then the sender waits for all results
  task automatic test_backpressure();
    drain_results();
    holdoff_request = 300;
    sender_idles    = 1'b0;
    repeat (80) begin
      if ($urandom_range(0, 3) == 0) send_noise();
      else send_request(hppc_pkg::MODE_TICK, 16'($urandom));
    end
    drain_results();
    receiver_stalls = 1'b0;
    run_random_mix(40);
    receiver_stalls = 1'b1;
    sender_idles    = 1'b1;
  endtask

  // test sequence
  initial begin
    horn_now         = 1'b0;
    pulse_pending    = 1'b0;
    hold_active      = 1'b0;
    pattern_running  = 1'b0;
    step_now         = '0;
    step_elapsed_ms  = '0;
    pulse_elapsed_ms = '0;
    pulse_len_ms     = '0;
    step_len_ms[0]   = 16'd1000;
    step_len_ms[1]   = 16'd1000;
    step_len_ms[2]   = 16'd1000;
    step_len_ms[3]   = 16'd1000;
    step_len_ms[4]   = 16'd2000;
    step_on_bits     = 5'd21;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_default_steps();
    test_directed_cases();
    test_long_pulse();
    test_setting_sweep();
    test_backpressure();

    drain_results();
    if (mismatch_count == 0) begin
      $display("horn_pulse_hold_pattern_controller_top: match");
    end else begin
      $display("horn_pulse_hold_pattern_controller_top: mismatch");
    end
    $finish;
  end

endmodule
